// ===== sv/chacha20_stream_cipher_top_macros.svh =====
// Assertion macros used by the cipher top level.
`ifndef CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
`define CHACHA20_STREAM_CIPHER_TOP_MACROS_SVH
// Concurrent assertion with an implication, disabled in reset.
`define CC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Concurrent assertion with a next-cycle implication, disabled in reset.
`define CC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== sv/chacha_pkg.sv =====
// Types and constants shared by the cipher modules.
`timescale 1ns / 1ps
`default_nettype none
package chacha_pkg;
   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;
   localparam logic [2:0] REG_KEY0 = 3'd0;
   localparam logic [2:0] REG_KEY1 = 3'd1;
   localparam logic [2:0] REG_KEY2 = 3'd2;
   localparam logic [2:0] REG_KEY3 = 3'd3;
   localparam logic [2:0] REG_NONCE_LOW = 3'd4;
   localparam logic [2:0] REG_NONCE_HIGH = 3'd5;
   localparam logic [2:0] REG_START_CNT = 3'd6;
   typedef logic [31:0] word_type;
   typedef word_type [15:0] block_type;
   typedef struct packed {
      logic start;
      logic last;
      logic [7:0] data;
   } item_type;

   function automatic word_type rotl(word_type v, int unsigned s);
      rotl = (v << s) | (v >> (32 - s));
   endfunction
endpackage
`default_nettype wire

// ===== sv/chacha20_stream_cipher_top.sv =====
// Top level of the ChaCha20 byte-stream cipher.
//  channel  dir  handshake             payload
//  req      in   req_tvalid/req_tready tdata=data_byte, tuser=start_req, tlast=last
//  rsp      out  rsp_tvalid/rsp_tready tdata=cipher_byte, tlast=last_out
//  csr      in   csr_valid/csr_ready   csr_index, csr_data
// A byte that needs a new block waits while the core builds it, one half round per
// cycle in the cell row; the input stays closed in the generate state until the
// block is done and that byte's output is registered. The other 63 bytes of a
// block use the stored keystream and need no new block.
// Reset is synchronous; keystream storage is not cleared.
// A stalled response holds its register and blocks further input.
`timescale 1ns / 1ps
`default_nettype none
`include "chacha20_stream_cipher_top_macros.svh"
module chacha20_stream_cipher_top
   import chacha_pkg::*;
#(
   parameter int unsigned DOUBLE_ROUNDS = 10
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // data_byte
   input  logic        req_tuser,  // start_req
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // cipher_byte
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);
   localparam logic [1:0] ST_RUN = 2'd0;
   localparam logic [1:0] ST_GEN = 2'd1;

   logic [63:0] key0_ff, key1_ff, key2_ff, key3_ff, nlo_ff;
   logic [31:0] nhi_ff, scnt_ff;
   logic [31:0] cnt_ff, cnt_in;
   logic [5:0] pos_ff, pos_in;
   logic [1:0] state_ff, state_in;
   block_type ks_ff, init, block;
   item_type hold_ff, hold_in;
   logic [7:0] out_data_ff, out_data_in;
   logic out_last_ff, out_last_in, out_valid_ff, out_valid_in;
   logic gen_start, gen_done, accept, room;
   logic [31:0] kword, cnt_use;
   logic [7:0] kbyte;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0; key1_ff <= '0; key2_ff <= '0; key3_ff <= '0;
         nlo_ff <= '0; nhi_ff <= '0; scnt_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_KEY0: key0_ff <= csr_data;
            REG_KEY1: key1_ff <= csr_data;
            REG_KEY2: key2_ff <= csr_data;
            REG_KEY3: key3_ff <= csr_data;
            REG_NONCE_LOW: nlo_ff <= csr_data;
            REG_NONCE_HIGH: nhi_ff <= csr_data[31:0];
            REG_START_CNT: scnt_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   assign room = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_RUN) && room;
   assign accept = req_tvalid && req_tready;

   // Counter for a block started by this byte.
   assign cnt_use = req_tuser ? scnt_ff : cnt_ff;
   assign gen_start = accept && (req_tuser || pos_ff == 6'd0);

   assign init = {nhi_ff, nlo_ff[63:32], nlo_ff[31:0], cnt_use,
                  key3_ff[63:32], key3_ff[31:0], key2_ff[63:32], key2_ff[31:0],
                  key1_ff[63:32], key1_ff[31:0], key0_ff[63:32], key0_ff[31:0],
                  SIGMA3, SIGMA2, SIGMA1, SIGMA0};

   chacha_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
      .clock(clock), .reset(reset), .start(gen_start), .init(init),
      .done(gen_done), .block(block)
   );

   always_comb begin
      kword = ks_ff[pos_ff[5:2]];
      kbyte = kword[8*pos_ff[1:0] +: 8];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pos_in = pos_ff;
      hold_in = hold_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_RUN: begin
            if (accept) begin
               if (gen_start) begin
                  state_in = ST_GEN;
                  cnt_in = cnt_use + 32'd1;
                  pos_in = 6'd0;
                  hold_in = '{start: req_tuser, last: req_tlast, data: req_tdata};
               end else begin
                  out_data_in = req_tdata ^ kbyte;
                  out_last_in = req_tlast;
                  out_valid_in = 1'b1;
                  pos_in = pos_ff + 6'd1;
               end
            end
         end
         ST_GEN: begin
            if (gen_done) begin
               state_in = ST_RUN;
               out_data_in = hold_ff.data ^ block[0][7:0];
               out_last_in = hold_ff.last;
               out_valid_in = 1'b1;
               pos_in = 6'd1;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff <= '0;
         pos_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
      end
      hold_ff <= hold_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (gen_done) begin
         ks_ff <= block;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tlast = out_last_ff;

   `CC_ASSERT_IMP(a_no_accept_in_gen, clock, reset, state_ff == ST_GEN, !req_tready)
   `CC_ASSERT_NEXT(a_gen_after_start, clock, reset, gen_start, state_ff == ST_GEN)
   `CC_ASSERT_NEXT(a_done_gives_out, clock, reset, state_ff == ST_GEN && gen_done, rsp_tvalid)
   `CC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready,
                   rsp_tvalid && $stable(rsp_tdata))
endmodule
`default_nettype wire

// ===== sv/chacha_qr_cell.sv =====
// One cell of the core's cell row: a combinational quarter round on four words.
`timescale 1ns / 1ps
`default_nettype none
module chacha_qr_cell
   import chacha_pkg::*;
(
   input  word_type a_in,
   input  word_type b_in,
   input  word_type c_in,
   input  word_type d_in,
   output word_type a_out,
   output word_type b_out,
   output word_type c_out,
   output word_type d_out
);
   word_type a1, b1, c1, d1, a2, b2, c2, d2;
   always_comb begin
      a1 = a_in + b_in;
      d1 = rotl(d_in ^ a1, 16);
      c1 = c_in + d1;
      b1 = rotl(b_in ^ c1, 12);
      a2 = a1 + b1;
      d2 = rotl(d1 ^ a2, 8);
      c2 = c1 + d2;
      b2 = rotl(b1 ^ c2, 7);
      a_out = a2;
      b_out = b2;
      c_out = c2;
      d_out = d2;
   end
endmodule
`default_nettype wire

// ===== sv/chacha_core.sv =====
// Block generator: a row of four quarter-round cells iterated over half rounds.
`timescale 1ns / 1ps
`default_nettype none
module chacha_core
   import chacha_pkg::*;
#(
   parameter int unsigned DOUBLE_ROUNDS = 10
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  block_type init,
   output logic      done,
   output block_type block
);
   localparam int unsigned HALF = 2 * DOUBLE_ROUNDS;
   localparam int unsigned CW = $clog2(HALF + 1);

   block_type work_ff, work_in, init_ff, perm, res;
   logic [CW-1:0] count_ff, count_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic diag;

   assign diag = count_ff[0];

   always_comb begin
      if (!diag) begin
         perm = work_ff;
      end else begin
         for (int i = 0; i < 4; i++) begin
            perm[i] = work_ff[i];
            perm[4 + i] = work_ff[4 + ((i + 1) % 4)];
            perm[8 + i] = work_ff[8 + ((i + 2) % 4)];
            perm[12 + i] = work_ff[12 + ((i + 3) % 4)];
         end
      end
   end

   block_type cell_out;
   for (genvar g = 0; g < 4; g++) begin : g_cell
      chacha_qr_cell u_cell (
         .a_in (perm[g]), .b_in (perm[4 + g]), .c_in (perm[8 + g]), .d_in (perm[12 + g]),
         .a_out(cell_out[g]), .b_out(cell_out[4 + g]),
         .c_out(cell_out[8 + g]), .d_out(cell_out[12 + g])
      );
   end

   always_comb begin
      if (!diag) begin
         res = cell_out;
      end else begin
         for (int i = 0; i < 4; i++) begin
            res[i] = cell_out[i];
            res[4 + ((i + 1) % 4)] = cell_out[4 + i];
            res[8 + ((i + 2) % 4)] = cell_out[8 + i];
            res[12 + ((i + 3) % 4)] = cell_out[12 + i];
         end
      end
   end

   always_comb begin
      work_in = work_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         work_in = init;
         count_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         work_in = res;
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(HALF - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      work_ff <= work_in;
      if (start) begin
         init_ff <= init;
      end
   end

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         block[i] = work_ff[i] + init_ff[i];
      end
   end
   assign done = done_ff;
endmodule
`default_nettype wire
